@@ design/mwa_pkg.sv @@
// Shared types, constants and the sample decoder of the metric window accumulator.
package mwa_pkg;

	// Widths fixed by the item and result formats.
	localparam int SAMPLE_W = 25;
	localparam int SUM_W    = 40;
	localparam int ENERGY_W = 48;
	localparam int ACC_W    = 49;
	localparam int INC_W    = 16;

	// Stream beat layout.
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 88;

	// Register reset values.
	localparam logic [15:0] KINDS_RESET  = 16'hE950;
	localparam logic [7:0]  WARMUP_RESET = 8'd18;

	// Configuration register indexes.
	localparam logic CFG_METRIC_KINDS = 1'b0;
	localparam logic CFG_WARMUP       = 1'b1;

	// Item operations.
	typedef enum logic [1:0] {
		OP_ADVANCE = 2'd0,
		OP_STORE   = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	// Sample kinds, two bits per metric.
	localparam logic [1:0] KIND_LOW_U  = 2'd0;
	localparam logic [1:0] KIND_LOW_S  = 2'd1;
	localparam logic [1:0] KIND_WORD_S = 2'd2;
	localparam logic [1:0] KIND_WORD_U = 2'd3;

	// Controls from the sequencer to the shared adder.
	typedef struct packed {
		logic clr_sum;
		logic add_sample;
		logic add_energy;
		logic clr_energy;
	} acc_ctrl_t;

	// Turns the raw register words into a signed sample of the given kind.
	function automatic logic signed [SAMPLE_W-1:0] decode_sample(
		input logic [1:0]  kind,
		input logic [15:0] hw,
		input logic [15:0] lw
	);
		logic signed [SAMPLE_W-1:0] s;
		case (kind)
			KIND_LOW_U:  s = {1'b0, hw, lw[15:8]};
			KIND_LOW_S:  s = {hw[15], hw, lw[15:8]};
			KIND_WORD_S: s = {{(SAMPLE_W-16){hw[15]}}, hw};
			KIND_WORD_U: s = {{(SAMPLE_W-16){1'b0}}, hw};
			default:     s = '0;
		endcase
		return s;
	endfunction

endpackage

@@ design/mwa_ram.sv @@
// Sample memory: one write port and one read port with registered read data.
module mwa_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [mwa_pkg::SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]                raddr,
	output logic [mwa_pkg::SAMPLE_W-1:0] rdata
);
	import mwa_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	// Write when we is set and read every cycle; read data lands in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/mwa_acc.sv @@
// Shared adder with the window sum and the saturating energy total.
module mwa_acc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mwa_pkg::acc_ctrl_t                  ctrl,
	input  logic signed [mwa_pkg::SAMPLE_W-1:0] sample,
	input  logic [mwa_pkg::INC_W-1:0]           pos_energy,
	input  logic [mwa_pkg::INC_W-1:0]           neg_energy,
	output logic signed [mwa_pkg::SUM_W-1:0]    sum,
	output logic signed [mwa_pkg::ENERGY_W-1:0] energy
);
	import mwa_pkg::*;

	localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
	localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

	logic signed [SUM_W-1:0]    sum_q;
	logic signed [ENERGY_W-1:0] energy_q;
	logic signed [INC_W:0]      delta;
	logic signed [ACC_W-1:0]    opa;
	logic signed [ACC_W-1:0]    opb;
	logic signed [ACC_W-1:0]    res;
	logic signed [ENERGY_W-1:0] energy_sat;

	// Net energy increment of an advance.
	assign delta = $signed({1'b0, pos_energy}) - $signed({1'b0, neg_energy});

	// Operand selection: energy update or one window sample.
	always_comb begin
		if (ctrl.add_energy) begin
			opa = {{(ACC_W-ENERGY_W){energy_q[ENERGY_W-1]}}, energy_q};
			opb = {{(ACC_W-INC_W-1){delta[INC_W]}}, delta};
		end else begin
			opa = {{(ACC_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
			opb = {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
		end
		res = opa + opb;
	end

	// Clamp the energy total when the sum leaves the 48-bit range.
	always_comb begin
		if (res[ACC_W-1] != res[ACC_W-2]) begin
			energy_sat = res[ACC_W-1] ? E_MIN : E_MAX;
		end else begin
			energy_sat = res[ENERGY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			sum_q    <= '0;
		end else begin
			if (ctrl.clr_energy) begin
				energy_q <= '0;
			end else if (ctrl.add_energy) begin
				energy_q <= energy_sat;
			end
			if (ctrl.clr_sum) begin
				sum_q <= '0;
			end else if (ctrl.add_sample) begin
				sum_q <= res[SUM_W-1:0];
			end
		end
	end

	assign sum    = sum_q;
	assign energy = energy_q;

endmodule

@@ design/metric_window_accumulator.sv @@
// Metric window accumulator: sequencer, registers and stream ports.
//
// Items arrive as beats on the s_axis channel: tuser carries the operation,
// tdata the metric, raw words, energy increments and window count. Every item
// yields exactly one result beat on m_axis: the window sum, the energy total
// and the warm-up ready flag. Registers are written on the cfg channel, which
// is always ready; writes belong in idle periods.
// The block works on one item at a time and drops s_axis_tready from the
// accept until the result is loaded into the output register. Advance, store
// and restart go from the execute state to the done state; a query walks its
// window count, clamped to 1 .. RING_DEPTH, in the read state and then passes
// the drain state, as the single read port of the sample memory is walked
// backward one entry per cycle into the shared adder.
// Queries on a metric outside the configured slots go straight to done.
// The output register holds a finished result while the receiver stalls; the
// next item is accepted meanwhile, and its result waits until the held beat
// is taken. Reset clears the energy total, the slot and the handshakes, loads
// the register defaults and the warm-up counter; sample memory is not cleared
// and must be written before it is queried.
module metric_window_accumulator #(
	parameter int RING_DEPTH   = 64,
	parameter int METRIC_SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// s_axis_tdata: metric, high_word, low_word, pos_energy, neg_energy,
	// window_count, zero pad (lowest bit first).
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [mwa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// s_axis_tuser: op.
	input  logic [1:0]                     s_axis_tuser,
	// m_axis_tdata: window_sum, net_energy (lowest bit first).
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mwa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// m_axis_tuser: ready_res.
	output logic                           m_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [15:0]                    cfg_data
);
	import mwa_pkg::*;

	localparam int SW        = $clog2(RING_DEPTH);
	localparam int MW        = (METRIC_SLOTS > 1) ? $clog2(METRIC_SLOTS) : 1;
	localparam int CW        = $clog2(RING_DEPTH + 1);
	localparam int AW        = MW + SW;
	localparam int MEM_DEPTH = METRIC_SLOTS * (1 << SW);
	localparam logic [SW-1:0] SLOT_LAST = SW'(RING_DEPTH - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	// Captured item.
	op_t         op_q;
	logic [2:0]  metric_q;
	logic [15:0] hw_q;
	logic [15:0] lw_q;
	logic [15:0] pos_q;
	logic [15:0] neg_q;
	logic [CW-1:0] left_q;

	// Block state and registers.
	logic [15:0]   kinds_q;
	logic [7:0]    warmup_cfg_q;
	logic [7:0]    warmup_left_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] rd_slot_q;
	logic          rd_valid_s1;

	// Output register.
	logic                       out_valid_q;
	logic signed [SUM_W-1:0]    out_sum_q;
	logic signed [ENERGY_W-1:0] out_energy_q;
	logic                       out_ready_q;

	logic          accept;
	logic          metric_ok;
	logic [6:0]    in_cnt;
	logic [CW-1:0] cnt_clamp;
	logic [1:0]    kind;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic          out_load;
	acc_ctrl_t     acc_ctrl;
	logic signed [SUM_W-1:0]    acc_sum;
	logic signed [ENERGY_W-1:0] acc_energy;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// Clamp the window count to 1 .. RING_DEPTH.
	assign in_cnt = s_axis_tdata[73:67];
	always_comb begin
		if (in_cnt == 7'd0) begin
			cnt_clamp = CW'(1);
		end else if ({25'd0, in_cnt} > 32'(RING_DEPTH)) begin
			cnt_clamp = CW'(RING_DEPTH);
		end else begin
			cnt_clamp = CW'(in_cnt);
		end
	end

	assign metric_ok = ({29'd0, metric_q} < 32'(METRIC_SLOTS));
	assign kind      = kinds_q[{metric_q, 1'b0} +: 2];

	// Memory access: store writes the current slot, a query walks backward.
	assign ram_we    = (state_q == ST_EXEC) && (op_q == OP_STORE) && metric_ok;
	assign ram_waddr = {metric_q[MW-1:0], slot_q};
	assign ram_wdata = decode_sample(kind, hw_q, lw_q);
	assign ram_raddr = {metric_q[MW-1:0], rd_slot_q};

	// Shared adder controls.
	always_comb begin
		acc_ctrl            = '0;
		acc_ctrl.clr_sum    = accept;
		acc_ctrl.add_sample = rd_valid_s1;
		acc_ctrl.add_energy = (state_q == ST_EXEC) && (op_q == OP_ADVANCE);
		acc_ctrl.clr_energy = (state_q == ST_EXEC) && (op_q == OP_RESTART);
	end

	mwa_ram #(
		.DEPTH (MEM_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mwa_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (acc_ctrl),
		.sample     ($signed(ram_rdata)),
		.pos_energy (pos_q),
		.neg_energy (neg_q),
		.sum        (acc_sum),
		.energy     (acc_energy)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kinds_q      <= KINDS_RESET;
			warmup_cfg_q <= WARMUP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_METRIC_KINDS: kinds_q <= cfg_data;
				CFG_WARMUP:       warmup_cfg_q <= cfg_data[7:0];
				default:          ;
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(s_axis_tuser);
			metric_q <= s_axis_tdata[2:0];
			hw_q     <= s_axis_tdata[18:3];
			lw_q     <= s_axis_tdata[34:19];
			pos_q    <= s_axis_tdata[50:35];
			neg_q    <= s_axis_tdata[66:51];
		end
	end

	// Sequencer with slot, warm-up and window walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_q        <= '0;
			rd_slot_q     <= '0;
			left_q        <= '0;
			warmup_left_q <= WARMUP_RESET;
			rd_valid_s1   <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						left_q  <= cnt_clamp;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (op_q)
						OP_ADVANCE: begin
							slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SW'(1);
							if (warmup_left_q != 8'd0) begin
								warmup_left_q <= warmup_left_q - 8'd1;
							end
						end
						OP_QUERY: begin
							if (metric_ok) begin
								rd_slot_q <= slot_q;
								state_q   <= ST_READ;
							end
						end
						OP_RESTART: begin
							slot_q        <= '0;
							warmup_left_q <= warmup_cfg_q;
						end
						default: ;
					endcase
				end
				ST_READ: begin
					rd_slot_q <= (rd_slot_q == '0) ? SLOT_LAST : rd_slot_q - SW'(1);
					left_q    <= left_q - CW'(1);
					if (left_q == CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sum_q    <= acc_sum;
			out_energy_q <= acc_energy;
			out_ready_q  <= (warmup_left_q == 8'd0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_energy_q, out_sum_q};
	assign m_axis_tuser  = out_ready_q;

endmodule

@@ design/mwa_checker.sv @@
// Port-level checks of the metric window accumulator and their binding.
module mwa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [1:0]                     s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [mwa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import mwa_pkg::*;

	// A result beat stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn before it was taken");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted while one is in progress");

	// Non-query items accepted with no result offered report a zero window sum after execute and done.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid && (s_axis_tuser != OP_QUERY)
		|-> ##3 (m_axis_tvalid && (m_axis_tdata[39:0] == 40'd0)))
		else $error("non-query result late or with a nonzero window sum");

	// A restart reports a cleared energy total.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid && (s_axis_tuser == OP_RESTART)
		|-> ##3 (m_axis_tdata[87:40] == 48'd0))
		else $error("restart result does not show a cleared energy total");

endmodule

bind metric_window_accumulator mwa_checker u_mwa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ test/tb_metric_window_accumulator.sv @@
// Self-checking testbench of the metric window accumulator with a scoreboard class.
module tb_metric_window_accumulator;
	import mwa_pkg::*;

	localparam int RING        = 64;
	localparam int SLOTS       = 8;
	localparam int ITEM_BUDGET = 1000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;

	// One input item as the block sees it.
	typedef struct {
		op_t         op;
		logic [2:0]  metric;
		logic [15:0] hw;
		logic [15:0] lw;
		logic [15:0] pos;
		logic [15:0] neg;
		logic [6:0]  cnt;
	} meter_item_t;

	// One expected result beat.
	typedef struct {
		logic [39:0] wsum;
		logic [47:0] energy;
		logic        rdy;
	} meter_result_t;

	// Tracks the accumulator state and the results still owed by the block.
	class window_tracker;
		logic signed [31:0] ring [SLOTS][RING];
		bit                 written [SLOTS][RING];
		logic [5:0]         slot;
		longint             energy;
		logic [7:0]         warm_left;
		logic [7:0]         warm_cfg;
		logic [15:0]        kinds;
		meter_result_t      owed [$];
		int errors, checked, reg_writes;
		int n_adv, n_store, n_query, n_full, n_restart;

		function new();
			slot = '0;
			energy = 0;
			kinds = KINDS_RESET;
			warm_cfg = WARMUP_RESET;
			warm_left = WARMUP_RESET;
			errors = 0;
			checked = 0;
			reg_writes = 0;
			n_adv = 0;
			n_store = 0;
			n_query = 0;
			n_full = 0;
			n_restart = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			reg_writes++;
			if (idx == CFG_METRIC_KINDS) begin
				kinds = val;
			end else begin
				warm_cfg = val[7:0];
			end
		endfunction

		// Number of written entries walking back from the current slot.
		function int reach(int m);
			int n;
			logic [5:0] p;
			n = 0;
			p = slot;
			while (n < RING && written[m][p]) begin
				n++;
				p = p - 1'b1;
			end
			return n;
		endfunction

		function int owed_count();
			return owed.size();
		endfunction

		// Applies one accepted item and queues the result it must produce.
		function void note_item(meter_item_t it);
			meter_result_t r;
			logic [1:0] kind;
			logic signed [31:0] smp;
			logic [5:0] p;
			longint acc;
			int span;
			acc = 0;
			case (it.op)
				OP_ADVANCE: begin
					n_adv++;
					if (warm_left != 0) warm_left--;
					energy = energy + longint'(it.pos) - longint'(it.neg);
					if (energy > 64'sh7FFF_FFFF_FFFF) energy = 64'sh7FFF_FFFF_FFFF;
					if (energy < -64'sh8000_0000_0000) energy = -64'sh8000_0000_0000;
					slot = slot + 1'b1;
				end
				OP_STORE: begin
					n_store++;
					kind = kinds[2*it.metric +: 2];
					case (kind)
						KIND_LOW_U:  smp = {8'h00, it.hw, it.lw[15:8]};
						KIND_LOW_S:  smp = {{8{it.hw[15]}}, it.hw, it.lw[15:8]};
						KIND_WORD_S: smp = {{16{it.hw[15]}}, it.hw};
						default:     smp = {16'h0000, it.hw};
					endcase
					ring[it.metric][slot] = smp;
					written[it.metric][slot] = 1'b1;
				end
				OP_QUERY: begin
					n_query++;
					span = (it.cnt == 0) ? 1 : ((it.cnt > RING) ? RING : int'(it.cnt));
					if (span == RING) n_full++;
					p = slot;
					for (int i = 0; i < span; i++) begin
						acc = acc + ring[it.metric][p];
						p = p - 1'b1;
					end
				end
				default: begin
					n_restart++;
					energy = 0;
					slot = '0;
					warm_left = warm_cfg;
				end
			endcase
			r.wsum = acc[39:0];
			r.energy = energy[47:0];
			r.rdy = (warm_left == 0);
			owed.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50) $display("MISMATCH: %s", msg);
		endtask

		// Compares one result beat with the oldest owed result.
		task check_result(logic [39:0] ws, logic [47:0] en, logic rd);
			meter_result_t e;
			checked++;
			if (owed.size() == 0) begin
				report("result beat with no item waiting");
				return;
			end
			e = owed.pop_front();
			if (ws !== e.wsum)
				report($sformatf("window_sum got %0d expected %0d", $signed(ws), $signed(e.wsum)));
			if (en !== e.energy)
				report($sformatf("net_energy got %0d expected %0d", $signed(en),
					$signed(e.energy)));
			if (rd !== e.rdy)
				report($sformatf("ready_res got %0b expected %0b", rd, e.rdy));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [15:0]           cfg_data;

	window_tracker tracker;
	int  items_sent;
	int  burst_left;
	bit  gaps_on;
	int  holds_asked;
	int  holds_done;
	int  cycle_count;
	int  rx_mode;
	int  rx_left;
	logic [15:0] rx_pattern;

	metric_window_accumulator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog on the whole run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result monitor: every accepted beat is checked in order.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata[39:0], m_axis_tdata[87:40], m_axis_tuser);
	end

	// Receiver: changing stall patterns, plus long hold-offs on request.
	initial begin
		m_axis_tready = 1'b0;
		holds_done = 0;
		rx_left = 0;
		rx_mode = 0;
		rx_pattern = 16'h0001;
		forever begin
			@(posedge clk);
			if (holds_done < holds_asked) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				holds_done++;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_pattern = 16'($urandom) | 16'h0001;
					rx_left = $urandom_range(16, 96);
				end
				rx_left--;
				rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
				case (rx_mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= rx_pattern[0];
					2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ~rx_pattern[0] | rx_pattern[1];
				endcase
			end
		end
	end

	// Offers one item, with a random gap at the end of each burst, until it is taken.
	task send_item(meter_item_t it);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= {6'b0, it.cnt, it.neg, it.pos, it.lw, it.hw, it.metric};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_item(it);
		items_sent++;
	endtask

	function automatic meter_item_t make_item(op_t op, int m);
		meter_item_t it;
		it.op = op;
		it.metric = m[2:0];
		it.lw = 16'($urandom);
		it.pos = 16'($urandom);
		it.neg = 16'($urandom);
		it.cnt = 7'($urandom);
		case ($urandom_range(0, 7))
			0:       it.hw = 16'h8000;
			1:       it.hw = 16'h7FFF;
			2:       it.hw = 16'hFFFF;
			3:       it.hw = 16'h0000;
			default: it.hw = 16'($urandom);
		endcase
		return it;
	endfunction

	task direct(op_t op, int m, logic [15:0] hw, logic [15:0] lw,
		logic [15:0] pos, logic [15:0] neg, logic [6:0] cnt);
		meter_item_t it;
		it = make_item(op, m);
		it.hw = hw;
		it.lw = lw;
		it.pos = pos;
		it.neg = neg;
		it.cnt = cnt;
		send_item(it);
	endtask

	// Queries only as far back as the ring of that metric has been written.
	task send_query(int m);
		meter_item_t it;
		int span;
		span = tracker.reach(m);
		if (span == 0) begin
			send_item(make_item(OP_STORE, m));
		end else begin
			it = make_item(OP_QUERY, m);
			case ($urandom_range(0, 7))
				0:       it.cnt = 7'd0;
				1, 2:    it.cnt = span[6:0];
				3:       it.cnt = (span == RING) ? 7'($urandom_range(65, 127)) : span[6:0];
				default: it.cnt = 7'($urandom_range(1, span));
			endcase
			send_item(it);
		end
	endtask

	// Stores the chosen metrics into each slot, then steps to the next one.
	task sweep_slots(int len, logic [7:0] mask);
		for (int s = 0; s < len; s++) begin
			for (int m = 0; m < SLOTS; m++)
				if (mask[m]) send_item(make_item(OP_STORE, m));
			send_item(make_item(OP_ADVANCE, $urandom_range(0, 7)));
		end
	endtask

	task run_random(int target);
		meter_item_t it;
		int k;
		int n;
		while (items_sent < target) begin
			k = $urandom_range(0, 15);
			if (k <= 5) begin
				sweep_slots((k == 0) ? RING : $urandom_range(1, 16), 8'($urandom_range(1, 255)));
			end else if (k <= 10) begin
				repeat ($urandom_range(1, 6)) send_query($urandom_range(0, 7));
			end else if (k <= 13) begin
				// Loose mix of any operation.
				repeat ($urandom_range(1, 8)) begin
					it = make_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 7));
					if (it.op == OP_QUERY) send_query(it.metric);
					else send_item(it);
				end
			end else if (k == 14) begin
				send_item(make_item(OP_RESTART, $urandom_range(0, 7)));
				n = ($urandom_range(0, 3) == 0) ? tracker.warm_cfg + 1 : $urandom_range(0, 8);
				repeat (n) send_item(make_item(OP_ADVANCE, $urandom_range(0, 7)));
			end else begin
				// Energy steps at the extremes of the increments.
				repeat ($urandom_range(1, 6)) begin
					it = make_item(OP_ADVANCE, $urandom_range(0, 7));
					if ($urandom_range(0, 1) == 1) begin
						it.pos = 16'hFFFF;
						it.neg = 16'h0000;
					end else begin
						it.pos = 16'h0000;
						it.neg = 16'hFFFF;
					end
					send_item(it);
				end
			end
		end
	endtask

	// Lets every owed result come back and the block settle.
	task drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (tracker.owed_count() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_reg(logic idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, val);
	endtask

	task set_config(logic [15:0] kinds, logic [7:0] warm);
		write_reg(CFG_METRIC_KINDS, kinds);
		write_reg(CFG_WARMUP, {8'h00, warm});
		cfg_valid <= 1'b0;
	endtask

	// Main sequence: reset, directed items, then random phases under changing settings.
	initial begin
		tracker = new();
		items_sent = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		holds_asked = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every metric at slot 0 with an all-ones high word and upper low byte, covering each sample kind.
		for (int m = 0; m < SLOTS; m++)
			direct(OP_STORE, m, 16'hFFFF, 16'hFF00, 16'h0000, 16'h0000, 7'd3);
		// Window count zero, then a single-sample window.
		direct(OP_QUERY, 2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0);
		direct(OP_QUERY, 7, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1);
		direct(OP_ADVANCE, 0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 7'd0);
		direct(OP_STORE, 1, 16'h8000, 16'h00FF, 16'h0000, 16'h0000, 7'd0);
		direct(OP_STORE, 3, 16'h7FFF, 16'h80FF, 16'h0000, 16'h0000, 7'd0);
		direct(OP_STORE, 4, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 7'd0);
		direct(OP_STORE, 5, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 7'd0);
		direct(OP_STORE, 6, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 7'd0);
		direct(OP_QUERY, 3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd2);
		direct(OP_QUERY, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd2);
		direct(OP_QUERY, 5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd2);
		direct(OP_ADVANCE, 0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 7'd0);
		direct(OP_ADVANCE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0);
		direct(OP_RESTART, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0);
		direct(OP_QUERY, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1);
		drain_results();

		gaps_on = 1'b1;
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				drain_results();
				case (ph)
					1:       set_config(16'h0000, 8'd0);
					2:       set_config(16'hFFFF, 8'd255);
					3:       set_config(16'($urandom), 8'($urandom));
					default: set_config(16'h1B1B, 8'd1);
				endcase
				// The new warm-up length only counts from the next restart.
				send_item(make_item(OP_ADVANCE, 0));
				send_item(make_item(OP_RESTART, 0));
			end
			if (ph == 0) begin
				// Fill two whole rings early so full-ring windows become legal.
				sweep_slots(RING, 8'h81);
			end
			if (ph == 2) holds_asked++;
			run_random(ITEM_BUDGET * (ph + 1) / 5);
		end

		drain_results();
		repeat (12) @(posedge clk);
		$display("Run covered %0d advances, %0d stores, %0d queries, %0d restarts.",
			tracker.n_adv, tracker.n_store, tracker.n_query, tracker.n_restart);
		$display("Full-ring queries: %0d, result beats checked: %0d, register writes: %0d.",
			tracker.n_full, tracker.checked, tracker.reg_writes);
		$display("Mismatches: %0d.", tracker.errors);
		if (tracker.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
